>>> rtl/core/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	// position of a byte within its three-byte group
	typedef enum logic [1:0] {
		PHASE_0 = 2'd0,
		PHASE_1 = 2'd1,
		PHASE_2 = 2'd2
	} phase_t;

	localparam int unsigned RUN_MAX   = 4;
	localparam int unsigned QUEUE_DEP = 2;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_LOWER = 8'h61;
	localparam logic [7:0] CHAR_DIGIT = 8'h30;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// characters that one input byte causes, as sextets or pad marks
	typedef struct packed {
		logic [RUN_MAX-1:0][5:0] sextet;
		logic [RUN_MAX-1:0]      pad;
		logic [1:0]              last_idx;
		logic                    fin;
	} run_t;

	// queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] c;
		begin
			w = {2'b00, v};
			if (v < 6'd26)
				c = CHAR_UPPER + w;
			else if (v < 6'd52)
				c = CHAR_LOWER + (w - 8'd26);
			else if (v < 6'd62)
				c = CHAR_DIGIT + (w - 8'd52);
			else if (v == 6'd62)
				c = CHAR_PLUS;
			else
				c = CHAR_SLASH;
			return c;
		end
	endfunction

endpackage

>>> rtl/core/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the group position and leftover bits, and
// builds the run of sextets and pads that each byte causes.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output b64e_pkg::run_t   run
);

	b64e_pkg::phase_t phase_q, phase_d;
	logic [3:0]       leftover_q, leftover_d;

	// classify the byte by group position
	always_comb begin
		run        = '0;
		run.fin    = final_byte;
		phase_d    = phase_q;
		leftover_d = leftover_q;
		unique case (phase_q)
			b64e_pkg::PHASE_1: begin
				run.sextet[0] = {leftover_q[1:0], data_byte[7:4]};
				run.sextet[1] = {data_byte[3:0], 2'b00};
				run.pad[2]    = 1'b1;
				run.last_idx  = final_byte ? 2'd2 : 2'd0;
				phase_d       = b64e_pkg::PHASE_2;
				leftover_d    = data_byte[3:0];
			end
			b64e_pkg::PHASE_2: begin
				run.sextet[0] = {leftover_q, data_byte[7:6]};
				run.sextet[1] = data_byte[5:0];
				run.last_idx  = 2'd1;
				phase_d       = b64e_pkg::PHASE_0;
				leftover_d    = 4'd0;
			end
			default: begin
				run.sextet[0] = data_byte[7:2];
				run.sextet[1] = {data_byte[1:0], 4'b0000};
				run.pad[2]    = 1'b1;
				run.pad[3]    = 1'b1;
				run.last_idx  = final_byte ? 2'd3 : 2'd0;
				phase_d       = b64e_pkg::PHASE_1;
				leftover_d    = {2'b00, data_byte[1:0]};
			end
		endcase
		// end of message returns to the start of a group
		if (final_byte) begin
			phase_d    = b64e_pkg::PHASE_0;
			leftover_d = 4'd0;
		end
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= b64e_pkg::PHASE_0;
			leftover_q <= 4'd0;
		end else if (take) begin
			phase_q    <= phase_d;
			leftover_q <= leftover_d;
		end
	end

endmodule

>>> rtl/core/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry queue of runs between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64e_pkg::run_t   push_run,
	input  logic             pop,
	output b64e_pkg::run_t   head,
	output b64e_pkg::qstat_t stat
);

	b64e_pkg::run_t [b64e_pkg::QUEUE_DEP-1:0] mem_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == 2'(b64e_pkg::QUEUE_DEP));
	assign stat.empty = (count_q == 2'd0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_run;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head run into the output register, one character per cycle while out_stall does not hold it.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64e_pkg::run_t   head,
	input  logic             head_valid,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_char,
	output logic             last_of_run,
	output logic             end_of_text
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       emit;
	logic       at_last;
	logic [7:0] ch;

	assign emit      = head_valid && (!valid_q || !out_stall);
	assign at_last   = (idx_q == head.last_idx);
	assign pop       = emit && at_last;
	assign out_valid = valid_q;

	// character for the current position
	always_comb begin
		if (head.pad[idx_q])
			ch = b64e_pkg::CHAR_PAD;
		else
			ch = b64e_pkg::sextet_char(head.sextet[idx_q]);
	end

	// position within the run and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (emit)
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			if (emit)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char    <= ch;
			last_of_run <= at_last;
			end_of_text <= at_last && head.fin;
		end
	end

endmodule

>>> rtl/core/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder: raw bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with data_byte and final_byte; a word
// is taken at a clock edge with in_valid high and in_stall low. Setting
// final_byte flushes the partial sextet and pads with '=' to four chars.
// Output channel: out_valid / out_stall with out_char, last_of_run (last
// char caused by one input byte) and end_of_text (last char of a message).
// Each byte yields one to four characters; the back end emits one character
// per cycle while out_stall does not hold the output register. A taken byte
// is written into the run queue and then into the output register, where
// its first character appears on the output.
// A two-entry queue sits between the byte classifier and the character
// serializer; in_stall rises only when that queue is full, so bytes keep
// flowing while the output register holds a stalled character.
// Reset clears the group position, the queue and the output valid; the
// block accepts input as soon as reset is released.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       end_of_text
);

	b64e_pkg::run_t   new_run;
	b64e_pkg::run_t   head;
	b64e_pkg::qstat_t qstat;
	logic             take;
	logic             pop;

	assign in_stall = qstat.full;
	assign take     = in_valid && !qstat.full;

	// byte classifier
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.run        (new_run)
	);

	// run queue
	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_run (new_run),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	// character serializer
	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!qstat.empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text)
	);

	// end of message always closes a run
	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_text |-> last_of_run)
		else $error("end_of_text without last_of_run");

	// queue never reports full and empty together
	a_qstat: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue status inconsistent");

	// a run leaves the queue only when one is present
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// a completed pop is followed by a valid character on the output
	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && last_of_run)
		else $error("run finished without its last character");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming base64 encoder.
// ----------------------------------------------------------------------------
// A short set of hand-picked messages covers all-zero and all-one bytes, the
// '+' and '/' characters, and messages that end at each position of the
// three-byte group. Random messages follow. The driver feeds the input words
// from a pending queue. At each accepted byte a local encoder model predicts
// the characters it should cause. The monitor compares every output word
// with the oldest prediction. The phases run with no idling, with the
// sender idle, with the receiver stalling, and with both. A last phase holds
// the output off for a long stretch while bytes keep coming, so that the
// block fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned HOLD_CYCLES    = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       eot;
	} char_word_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [7:0] data_byte   = 8'h00;
	logic       final_byte  = 1'b0;
	logic       out_stall   = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] out_char;
	logic       last_of_run;
	logic       end_of_text;

	byte_word_t pending_bytes[$];
	char_word_t expected_chars[$];

	// encoder model state
	b64e_pkg::phase_t enc_phase = b64e_pkg::PHASE_0;
	logic [3:0]       enc_left  = 4'h0;
	string            b64_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned mismatches    = 0;
	int unsigned idle_cycles   = 0;
	int unsigned hold_left     = 0;
	logic        hold_req      = 1'b0;

	base64_stream_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text)
	);

	always #2 clk = ~clk;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		return b64_alphabet[v];
	endfunction

	// work out the characters one byte causes and queue them
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [7:0] run[4];
		int         n;
		n = 0;
		case (enc_phase)
			b64e_pkg::PHASE_1: begin
				run[0] = b64_char({enc_left[1:0], b[7:4]});
				n = 1;
				enc_left = b[3:0];
				enc_phase = b64e_pkg::PHASE_2;
				if (fin) begin
					run[1] = b64_char({b[3:0], 2'b00});
					run[2] = b64e_pkg::CHAR_PAD;
					n = 3;
				end
			end
			b64e_pkg::PHASE_2: begin
				run[0] = b64_char({enc_left, b[7:6]});
				run[1] = b64_char(b[5:0]);
				n = 2;
				enc_left = 4'h0;
				enc_phase = b64e_pkg::PHASE_0;
			end
			// start of a group; an unused phase value lands here too
			default: begin
				run[0] = b64_char(b[7:2]);
				n = 1;
				enc_left = {2'b00, b[1:0]};
				enc_phase = b64e_pkg::PHASE_1;
				if (fin) begin
					run[1] = b64_char({b[1:0], 4'h0});
					run[2] = b64e_pkg::CHAR_PAD;
					run[3] = b64e_pkg::CHAR_PAD;
					n = 4;
				end
			end
		endcase
		for (int i = 0; i < n; i++)
			expected_chars.insert(expected_chars.size(),
				char_word_t'{run[i], i == n - 1, fin && (i == n - 1)});
		// end of message returns to a fresh group
		if (fin) begin
			enc_phase = b64e_pkg::PHASE_0;
			enc_left = 4'h0;
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic fin);
		pending_bytes.insert(pending_bytes.size(), byte_word_t'{b, fin});
	endtask

	// random messages, mostly short, until about the given number of bytes
	task automatic queue_random(input int unsigned nbytes);
		int unsigned total;
		int unsigned len;
		logic [7:0]  b;
		total = 0;
		while (total < nbytes) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
			for (int unsigned i = 0; i < len; i++) begin
				case ($urandom_range(0, 15))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				push_byte(b, i == len - 1);
			end
			total += len;
		end
	endtask

	// wait until every byte is taken and every char has come out
	task automatic wait_drain();
		@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned nbytes);
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		queue_random(nbytes);
		wait_drain();
	endtask

	// driver: offer the next word once the current one is taken
	always @(posedge clk or negedge arst_n) begin : drive_in
		byte_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			final_byte <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				encode_byte(data_byte, final_byte);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					w = pending_bytes.pop_front();
					in_valid <= 1'b1;
					data_byte <= w.data;
					final_byte <= w.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each output word, then pick the next stall
	always @(posedge clk or negedge arst_n) begin : watch_out
		char_word_t got;
		char_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{out_char, last_of_run, end_of_text};
				if (expected_chars.size() == 0) begin
					if (mismatches < 10)
						$display("extra char %h last %b end %b with nothing expected",
							got.ch, got.last, got.eot);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("expected char %h last %b end %b, got char %h last %b end %b",
								want.ch, want.last, want.eot, got.ch, got.last, got.eot);
						mismatches++;
					end
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
		end
	end

	// long output hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// hand-picked messages ending at every group position
		@(negedge clk);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBE, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hF8, 1'b0);
		push_byte(8'h3E, 1'b1);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hC0, 1'b1);
		wait_drain();

		run_phase(0, 0, 90);
		run_phase(46, 0, 90);
		run_phase(0, 46, 90);
		run_phase(35, 35, 90);

		// fill the block while the output is held off
		@(negedge clk);
		send_idle_pct = 0;
		stall_pct = 0;
		queue_random(30);
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		wait_drain();

		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
test/testbench.sv
